### src/triangle_tangent_generator_assert.svh
// Assertion macros used by the tangent generator back end.
`ifndef TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH
`define TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH

// Implication or plain property checked on every clock outside reset.
`define TTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define TTG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/ttg_pkg.sv
// Types, widths and helper functions for the tangent generator.
package ttg_pkg;

  localparam int CW     = 32;
  localparam int NW     = 16;
  localparam int WW     = 64;
  localparam int MW     = 33;
  localparam int QW     = 17;
  localparam int TW     = 17;
  localparam int QDEPTH = 2;

  localparam logic [CW-1:0] DELTA_MAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] DELTA_MIN = 32'h8000_0001;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] tex_u;
    logic signed [CW-1:0] tex_v;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
  } vtx_t;

  typedef struct packed {
    logic signed [NW-1:0] tangent_x;
    logic signed [NW-1:0] tangent_y;
    logic signed [NW-1:0] tangent_z;
    logic                 used_fallback;
  } res_t;

  typedef struct packed {
    logic [2:0][CW-1:0] e1;
    logic [2:0][CW-1:0] e2;
    logic [CW-1:0]      du1;
    logic [CW-1:0]      dv1;
    logic [CW-1:0]      du2;
    logic [CW-1:0]      dv2;
    logic [2:0][NW-1:0] n;
  } tri_t;

  function automatic logic [CW-1:0] sat_delta(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [CW:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    if (d > $signed({1'b0, DELTA_MAX})) return DELTA_MAX;
    if (d < $signed({1'b1, DELTA_MIN})) return DELTA_MIN;
    return d[CW-1:0];
  endfunction

  function automatic logic [WW-1:0] mag64(input logic [WW-1:0] x);
    return x[WW-1] ? (WW'(0) - x) : x;
  endfunction

  function automatic logic [MW-1:0] sx32(input logic [CW-1:0] x);
    return {x[CW-1], x};
  endfunction

  function automatic logic [MW-1:0] sx16(input logic [NW-1:0] x);
    return {{(MW-NW){x[NW-1]}}, x};
  endfunction

  function automatic logic [WW-1:0] sx64n(input logic [NW-1:0] x);
    return {{(WW-NW){x[NW-1]}}, x};
  endfunction

  function automatic logic [WW-1:0] sx64t(input logic [TW-1:0] x);
    return {{(WW-TW){x[TW-1]}}, x};
  endfunction

  function automatic logic [NW-1:0] sat16(input logic [TW-1:0] x);
    if (!x[TW-1] && (x[TW-2] != x[TW-1])) return 16'h7fff;
    if (x[TW-1] && (x[TW-2] != x[TW-1])) return 16'h8000;
    return x[NW-1:0];
  endfunction

endpackage

### src/ttg_front.sv
// Vertex grouping: holds the first two vertices and forms triangle edge requests.
module ttg_front import ttg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  vtx_t vtx_i,
  output logic tri_push_o,
  output tri_t tri_o,
  input  logic tri_full_i
);

  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_THIRD, PH_SPARE} phase_e;

  phase_e             phase_q;
  vtx_t               v0_q;
  logic [2:0][CW-1:0] p1_q;
  logic [1:0][CW-1:0] uv1_q;
  logic               acc;

  assign full       = (phase_q == PH_THIRD) && tri_full_i;
  assign acc        = push && !full;
  assign tri_push_o = acc && (phase_q == PH_THIRD);

  always_comb begin
    tri_o.e1[0] = sat_delta(p1_q[0], v0_q.pos_x);
    tri_o.e1[1] = sat_delta(p1_q[1], v0_q.pos_y);
    tri_o.e1[2] = sat_delta(p1_q[2], v0_q.pos_z);
    tri_o.e2[0] = sat_delta(vtx_i.pos_x, v0_q.pos_x);
    tri_o.e2[1] = sat_delta(vtx_i.pos_y, v0_q.pos_y);
    tri_o.e2[2] = sat_delta(vtx_i.pos_z, v0_q.pos_z);
    tri_o.du1   = sat_delta(uv1_q[0], v0_q.tex_u);
    tri_o.dv1   = sat_delta(uv1_q[1], v0_q.tex_v);
    tri_o.du2   = sat_delta(vtx_i.tex_u, v0_q.tex_u);
    tri_o.dv2   = sat_delta(vtx_i.tex_v, v0_q.tex_v);
    tri_o.n[0]  = v0_q.normal_x;
    tri_o.n[1]  = v0_q.normal_y;
    tri_o.n[2]  = v0_q.normal_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
    end else if (acc) begin
      unique case (phase_q)
        PH_SECOND: begin
          p1_q[0]  <= vtx_i.pos_x;
          p1_q[1]  <= vtx_i.pos_y;
          p1_q[2]  <= vtx_i.pos_z;
          uv1_q[0] <= vtx_i.tex_u;
          uv1_q[1] <= vtx_i.tex_v;
          phase_q  <= PH_THIRD;
        end
        PH_THIRD: begin
          phase_q <= PH_FIRST;
        end
        default: begin
          v0_q    <= vtx_i;
          phase_q <= PH_SECOND;
        end
      endcase
    end
  end

endmodule

### src/ttg_queue.sv
// Short queue of triangle requests between the front and the back.
module ttg_queue import ttg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tri_t data_i,
  output logic full_o,
  input  logic pop_i,
  output tri_t data_o,
  output logic empty_o
);

  localparam int PW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  tri_t            mem_q [QDEPTH];
  logic [PW-1:0]   wptr_q;
  logic [PW-1:0]   rptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            wr;
  logic            rd;

  assign full_o  = (cnt_q == CNTW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) begin
        wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (rd) begin
        rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/ttg_back.sv
// Tangent sequencer: shared multiplier, root and divider units, result register.
`include "triangle_tangent_generator_assert.svh"
module ttg_back import ttg_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tri_empty_i,
  input  tri_t tri_i,
  output logic tri_pop_o,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  localparam int            F2      = 2 * NORMAL_FRAC_BITS;
  localparam logic [WW-1:0] DET_EPS = (WW'(1) << (2 * COORD_FRAC_BITS)) / WW'(1000000);
  localparam logic [TW-1:0] NSCALE  = TW'(1) << NORMAL_FRAC_BITS;
  localparam logic [21:0]   NY_LIM  = 22'(19) << NORMAL_FRAC_BITS;
  localparam int            DCW     = $clog2(QW);

  typedef enum logic [4:0] {
    S_IDLE, S_DET0, S_DET1, S_DET2, S_CHK, S_M0, S_M1, S_M2, S_RED0, S_RED,
    S_DOT0, S_DOT1, S_W0, S_W1, S_W2, S_SQ0, S_SQ1, S_SQRT, S_DIV0, S_DIV,
    S_LEN0, S_LEN1, S_FB0, S_FB1, S_DONE
  } state_e;

  typedef enum logic [1:0] {J_MAIN, J_NORM, J_CROSS} job_e;

  state_e               state_q;
  job_e                 job_q;
  logic                 red2_q;
  tri_t                 tri_q;
  logic [WW-1:0]        det_q;
  logic [WW-1:0]        acc_q;
  logic [2*MW-1:0]      p_q;
  logic [2:0][WW-1:0]   v_q;
  logic [1:0]           j_q;
  logic [6:0]           sh_q;
  logic [6:0]           s_q;
  logic [6:0]           s2_q;
  logic [WW-1:0]        mx_q;
  logic [47:0]          dot_q;
  logic [WW-1:0]        x_q;
  logic [WW-1:0]        r_q;
  logic [WW-1:0]        bit_q;
  logic [4:0]           cnt_q;
  logic [CW-1:0]        len_q;
  logic [CW-1:0]        rem_q;
  logic [QW-1:0]        dlo_q;
  logic [QW-1:0]        quo_q;
  logic [DCW-1:0]       dcnt_q;
  logic [2:0][TW-1:0]   t_q;
  logic                 fb_q;
  res_t                 res_q;
  logic                 res_valid_q;

  logic signed [MW-1:0]   ma;
  logic signed [MW-1:0]   mb;
  logic signed [2*MW-1:0] prod;
  logic [WW-1:0]          psum;
  logic [WW-1:0]          vj;
  logic [WW-1:0]          mx_c;
  logic                   red_busy;
  logic [WW-1:0]          rb;
  logic                   sq_ge;
  logic [WW-1:0]          x_n;
  logic [WW-1:0]          r_n;
  logic [WW-1:0]          num;
  logic [CW:0]            r2;
  logic                   dv_ge;
  logic [CW:0]            rem_n;
  logic [QW-1:0]          q_n;
  logic [TW-1:0]          q_t;
  logic [8:0]             ee;
  logic [4:0]             kk;
  logic [WW-1:0]          bmag;
  logic [WW-1:0]          lena;
  logic                   too_short;
  logic                   nzero;
  logic [TW-1:0]          n1m;
  logic                   use_y;
  logic [2:0][TW-1:0]     cr;
  logic                   czero;
  state_e                 u_next;
  logic                   res_load;

  assign prod      = ma * mb;
  assign psum      = acc_q + p_q[WW-1:0];
  assign vj        = v_q[j_q];
  assign tri_pop_o = (state_q == S_IDLE) && !tri_empty_i;
  assign empty     = !res_valid_q;
  assign res_o     = res_q;
  assign res_load  = (state_q == S_DONE) && (!res_valid_q || pop);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_DET0: begin ma = sx32(tri_q.du1);     mb = sx32(tri_q.dv2); end
      S_DET1: begin ma = sx32(tri_q.du2);     mb = sx32(tri_q.dv1); end
      S_M0:   begin ma = sx32(tri_q.e1[j_q]); mb = sx32(tri_q.dv2); end
      S_M1:   begin ma = sx32(tri_q.e2[j_q]); mb = sx32(tri_q.dv1); end
      S_DOT0: begin ma = sx16(tri_q.n[j_q]);  mb = vj[MW-1:0]; end
      S_W0:   begin ma = sx16(tri_q.n[j_q]);  mb = {{(MW-24){dot_q[47]}}, dot_q[47:24]}; end
      S_W1:   begin ma = sx16(tri_q.n[j_q]);  mb = {{(MW-24){1'b0}}, dot_q[23:0]}; end
      S_SQ0:  begin ma = vj[MW-1:0];          mb = vj[MW-1:0]; end
      S_LEN0: begin ma = {1'b0, len_q};       mb = MW'(100000); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    mx_c     = mag64(v_q[0]) | mag64(v_q[1]) | mag64(v_q[2]);
    red_busy = red2_q ? (|mx_q[WW-1:31]) : (|mx_q[WW-1:30]);

    rb    = r_q + bit_q;
    sq_ge = (x_q >= rb);
    x_n   = sq_ge ? (x_q - rb) : x_q;
    r_n   = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);

    num   = (mag64(vj) << NORMAL_FRAC_BITS) + {33'd0, len_q[CW-1:1]};
    r2    = {rem_q, dlo_q[QW-1]};
    dv_ge = (r2 >= {1'b0, len_q});
    rem_n = dv_ge ? (r2 - {1'b0, len_q}) : r2;
    q_n   = {quo_q[QW-2:0], dv_ge};
    q_t   = vj[WW-1] ? (TW'(0) - TW'(q_n)) : TW'(q_n);

    ee   = 9'(s_q) + 9'(s2_q) - 9'(F2);
    kk   = 5'(9'(0) - ee);
    bmag = mag64(det_q);
    lena = p_q[WW-1:0];
    if (!ee[8]) begin
      too_short = (ee >= 9'd64) ? (lena == '0) : (lena <= (bmag >> ee[5:0]));
    end else begin
      too_short = ((lena + ((WW'(1) << kk) - WW'(1))) >> kk) <= bmag;
    end

    nzero = (tri_q.n[0] == '0) && (tri_q.n[1] == '0) && (tri_q.n[2] == '0);
    n1m   = t_q[1][TW-1] ? (TW'(0) - t_q[1]) : t_q[1];
    use_y = ((22'(n1m) * 22'd20) < NY_LIM);
    if (use_y) begin
      cr[0] = t_q[2];
      cr[1] = '0;
      cr[2] = TW'(0) - t_q[0];
    end else begin
      cr[0] = '0;
      cr[1] = TW'(0) - t_q[2];
      cr[2] = t_q[1];
    end
    czero = (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);

    unique case (job_q)
      J_NORM:  u_next = S_FB1;
      J_CROSS: u_next = S_DONE;
      default: u_next = S_LEN0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_MAIN;
      red2_q      <= 1'b0;
      res_valid_q <= 1'b0;
      j_q         <= '0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      sh_q        <= '0;
    end else begin
      p_q <= prod;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!tri_empty_i) begin
            tri_q   <= tri_i;
            state_q <= S_DET0;
          end
        end
        S_DET0: state_q <= S_DET1;
        S_DET1: begin
          acc_q   <= p_q[WW-1:0];
          state_q <= S_DET2;
        end
        S_DET2: begin
          det_q   <= acc_q - p_q[WW-1:0];
          state_q <= S_CHK;
        end
        S_CHK: begin
          j_q <= '0;
          if (bmag <= DET_EPS) begin
            fb_q    <= 1'b1;
            state_q <= S_FB0;
          end else begin
            fb_q    <= 1'b0;
            state_q <= S_M0;
          end
        end
        S_M0: state_q <= S_M1;
        S_M1: begin
          acc_q   <= p_q[WW-1:0];
          state_q <= S_M2;
        end
        S_M2: begin
          v_q[j_q] <= det_q[WW-1] ? (p_q[WW-1:0] - acc_q) : (acc_q - p_q[WW-1:0]);
          if (j_q == 2'd2) begin
            red2_q  <= 1'b0;
            state_q <= S_RED0;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_M0;
          end
        end
        S_RED0: begin
          mx_q    <= mx_c;
          sh_q    <= '0;
          state_q <= S_RED;
        end
        S_RED: begin
          if (red_busy) begin
            mx_q <= mx_q >> 1;
            sh_q <= sh_q + 1'b1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              v_q[i] <= v_q[i][WW-1] ? (WW'(0) - (mag64(v_q[i]) >> sh_q))
                                      : (mag64(v_q[i]) >> sh_q);
            end
            acc_q <= '0;
            j_q   <= '0;
            if (!red2_q) begin
              s_q     <= sh_q;
              state_q <= S_DOT0;
            end else begin
              s2_q    <= sh_q;
              job_q   <= J_MAIN;
              state_q <= S_SQ0;
            end
          end
        end
        S_DOT0: state_q <= S_DOT1;
        S_DOT1: begin
          acc_q <= psum;
          if (j_q == 2'd2) begin
            dot_q   <= psum[47:0];
            j_q     <= '0;
            state_q <= S_W0;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_DOT0;
          end
        end
        S_W0: state_q <= S_W1;
        S_W1: begin
          acc_q   <= (vj << F2) - (p_q[WW-1:0] << 24);
          state_q <= S_W2;
        end
        S_W2: begin
          v_q[j_q] <= acc_q - p_q[WW-1:0];
          if (j_q == 2'd2) begin
            red2_q  <= 1'b1;
            state_q <= S_RED0;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_W0;
          end
        end
        S_SQ0: state_q <= S_SQ1;
        S_SQ1: begin
          acc_q <= psum;
          if (j_q == 2'd2) begin
            x_q     <= psum;
            r_q     <= '0;
            bit_q   <= WW'(1) << (WW - 2);
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_SQ0;
          end
        end
        S_SQRT: begin
          x_q   <= x_n;
          r_q   <= r_n;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) begin
            len_q <= r_n[CW-1:0];
            j_q   <= '0;
            if (r_n == '0) begin
              t_q     <= '0;
              state_q <= u_next;
            end else begin
              state_q <= S_DIV0;
            end
          end
        end
        S_DIV0: begin
          rem_q   <= num[QW+CW-1:QW];
          dlo_q   <= num[QW-1:0];
          quo_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= rem_n[CW-1:0];
          dlo_q  <= dlo_q << 1;
          quo_q  <= q_n;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCW'(QW - 1)) begin
            t_q[j_q] <= q_t;
            if (j_q == 2'd2) begin
              state_q <= u_next;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_DIV0;
            end
          end
        end
        S_LEN0: state_q <= S_LEN1;
        S_LEN1: begin
          if ((len_q == '0) || too_short) begin
            fb_q    <= 1'b1;
            state_q <= S_FB0;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FB0: begin
          if (nzero) begin
            t_q[0]  <= '0;
            t_q[1]  <= NSCALE;
            t_q[2]  <= '0;
            state_q <= S_FB1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              v_q[i] <= sx64n(tri_q.n[i]) << 8;
            end
            acc_q   <= '0;
            j_q     <= '0;
            job_q   <= J_NORM;
            state_q <= S_SQ0;
          end
        end
        S_FB1: begin
          if (czero) begin
            t_q[0]  <= NSCALE;
            t_q[1]  <= '0;
            t_q[2]  <= '0;
            state_q <= S_DONE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              v_q[i] <= sx64t(cr[i]) << 8;
            end
            acc_q   <= '0;
            j_q     <= '0;
            job_q   <= J_CROSS;
            state_q <= S_SQ0;
          end
        end
        S_DONE: begin
          if (res_load) begin
            res_q.tangent_x     <= sat16(t_q[0]);
            res_q.tangent_y     <= sat16(t_q[1]);
            res_q.tangent_z     <= sat16(t_q[2]);
            res_q.used_fallback <= fb_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TTG_ASSERT(a_pop_nonempty, tri_pop_o |-> !tri_empty_i, "triangle request taken from empty queue")
  `TTG_NEVER(a_div_len, (state_q == S_DIV) && (len_q == '0), "division started with zero length")
  `TTG_ASSERT(a_res_src, $rose(res_valid_q) |-> $past(state_q == S_DONE), "result without completion")

endmodule

### src/triangle_tangent_generator.sv
// Top level of the per-triangle tangent generator.
// Vertices are taken one per cycle while full is low; every third vertex queues a triangle request.
// Each result is formed by a bit-serial square root, a divider pass per component and shift
// reductions; the back end takes a new triangle only once the last result is loaded.
// Two requests queue and one result is held.
// Reset is asynchronous and active low; no clearing pass follows it.
module triangle_tangent_generator import ttg_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  vtx_t vtx_i,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  tri_t tri_in;
  tri_t tri_out;
  logic tri_push;
  logic tri_full;
  logic tri_pop;
  logic tri_empty;

  ttg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .vtx_i      (vtx_i),
    .tri_push_o (tri_push),
    .tri_o      (tri_in),
    .tri_full_i (tri_full)
  );

  ttg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tri_push),
    .data_i  (tri_in),
    .full_o  (tri_full),
    .pop_i   (tri_pop),
    .data_o  (tri_out),
    .empty_o (tri_empty)
  );

  ttg_back #(
    .COORD_FRAC_BITS  (COORD_FRAC_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_empty_i (tri_empty),
    .tri_i       (tri_out),
    .tri_pop_o   (tri_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

endmodule
